// File: design/sjs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjs_pkg
// Shared types and codes of the two-processor job scheduler.
// ----------------------------------------------------------------------------
package sjs_pkg;

	localparam int unsigned ARR_W  = 10;
	localparam int unsigned LEN_W  = 8;
	localparam int unsigned LAB_W  = 6;
	localparam int unsigned TICK_W = 16;
	localparam int unsigned AVG_W  = 24;
	localparam int unsigned WSUM_W = 32;
	localparam int unsigned DIV_W  = 32;

	localparam logic [1:0] POL_FCFS = 2'd0;
	localparam logic [1:0] POL_SJF  = 2'd1;
	localparam logic [1:0] POL_HRRN = 2'd2;

	localparam logic KIND_DISPATCH = 1'b0;
	localparam logic KIND_SUMMARY  = 1'b1;

	localparam logic [AVG_W-1:0] MAX24 = {AVG_W{1'b1}};

	typedef struct packed {
		logic [ARR_W-1:0] arr;
		logic [LEN_W-1:0] len;
		logic [LAB_W-1:0] lab;
	} job_t;

endpackage

// File: design/sjs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjs_div
// Restoring divider, one quotient bit per cycle, 8-bit non-zero divisor.
// ----------------------------------------------------------------------------
module sjs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sjs_pkg::DIV_W-1:0]     dividend,
	input  logic [sjs_pkg::LEN_W-1:0]     divisor,
	output logic                          done,
	output logic [sjs_pkg::DIV_W-1:0]     quotient
);

	localparam int unsigned CW = $clog2(sjs_pkg::DIV_W + 1);

	logic [CW-1:0]                 cnt_q;
	logic                          done_q;
	logic [sjs_pkg::LEN_W-1:0]     rem_q;
	logic [sjs_pkg::LEN_W-1:0]     dvs_q;
	logic [sjs_pkg::DIV_W-1:0]     quo_q;
	logic [sjs_pkg::LEN_W:0]       trial;
	logic                          fits;

	assign trial = {rem_q, quo_q[sjs_pkg::DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(sjs_pkg::DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? sjs_pkg::LEN_W'(trial - {1'b0, dvs_q})
			              : trial[sjs_pkg::LEN_W-1:0];
			quo_q <= {quo_q[sjs_pkg::DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: design/sjs_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sjs_cmp
// Decides whether a candidate job beats the current best under the policy.
// ----------------------------------------------------------------------------
module sjs_cmp (
	input  logic [1:0]                  policy,
	input  logic [sjs_pkg::TICK_W-1:0]  tick,
	input  logic [sjs_pkg::ARR_W-1:0]   cand_arr,
	input  logic [sjs_pkg::LEN_W-1:0]   cand_len,
	input  logic [sjs_pkg::ARR_W-1:0]   best_arr,
	input  logic [sjs_pkg::LEN_W-1:0]   best_len,
	output logic                        better
);

	localparam int unsigned PW = sjs_pkg::TICK_W + sjs_pkg::LEN_W;

	logic [sjs_pkg::TICK_W-1:0] wait_c;
	logic [sjs_pkg::TICK_W-1:0] wait_b;
	logic [PW-1:0]              wi;
	logic [PW-1:0]              wb;

	// Both jobs have arrived, so the waits never wrap.
	assign wait_c = tick - sjs_pkg::TICK_W'(cand_arr);
	assign wait_b = tick - sjs_pkg::TICK_W'(best_arr);
	assign wi     = PW'(wait_c) * PW'(best_len);
	assign wb     = PW'(wait_b) * PW'(cand_len);

	always_comb begin
		case (policy)
			sjs_pkg::POL_SJF:  better = cand_len < best_len;
			sjs_pkg::POL_HRRN: better = wi > wb;
			default:           better = 1'b0;
		endcase
	end

endmodule

// File: design/two_cpu_job_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_cpu_job_scheduler_top
// Loads jobs, simulates two non-preemptive processors and reports dispatches and a summary.
// ----------------------------------------------------------------------------
// Loading accepts one word per cycle; a word without last_job frees start at once.
// Per simulated tick each processor in turn passes pick, run and next; an idle
// one first scans every loaded slot and may dispatch, and a finish waits on the
// shared serial divider. The summary follows the last finish after two divisions.
// Results cannot be stalled: result_strobe marks each word for one cycle only.
// Reset clears all control state; the job memory holds garbage until loaded.
module two_cpu_job_scheduler_top #(
	parameter int unsigned JOBS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        start,
	output logic        busy,
	input  logic [9:0]  arrival_time,
	input  logic [7:0]  run_length,
	input  logic [5:0]  job_label,
	input  logic        last_job,
	output logic        result_strobe,
	output logic        record_kind,
	output logic        cpu_index,
	output logic [5:0]  dispatched_label,
	output logic [15:0] dispatch_tick,
	output logic [23:0] avg_turnaround,
	output logic [23:0] avg_weighted_turnaround,
	output logic        last_result
);

	localparam int unsigned LW = $clog2(JOBS + 1);
	localparam int unsigned IW = (JOBS > 1) ? $clog2(JOBS) : 1;
	localparam int unsigned TAW = sjs_pkg::TICK_W + 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PICK, ST_SCAN_A, ST_SCAN_C, ST_DISP, ST_RUN, ST_FIN_W,
		ST_NEXT, ST_SUM_T, ST_SUM_TW, ST_SUM_W, ST_SUM_WW, ST_SUM_OUT
	} state_t;

	state_t state_q;

	// Job memory: written while loading, read one slot at a time by the scan.
	sjs_pkg::job_t job_mem [JOBS];
	sjs_pkg::job_t rd_q;

	logic [1:0]                   policy_q;
	logic [JOBS-1:0]              started_q;
	logic [LW-1:0]                loaded_q;
	logic [LW-1:0]                done_cnt_q;
	logic [IW-1:0]                scan_q;
	logic                         cur_cpu_q;
	logic [sjs_pkg::TICK_W-1:0]   tick_q;

	logic                         found_q;
	logic [IW-1:0]                best_slot_q;
	sjs_pkg::job_t                best_q;

	logic [1:0]                   cpu_busy_q;
	logic [sjs_pkg::LEN_W-1:0]    cpu_rem_q [2];
	logic [sjs_pkg::ARR_W-1:0]    cpu_arr_q [2];
	logic [sjs_pkg::LEN_W-1:0]    cpu_len_q [2];

	logic [sjs_pkg::AVG_W-1:0]    ta_sum_q;
	logic [sjs_pkg::WSUM_W-1:0]   w_sum_q;
	logic [sjs_pkg::AVG_W-1:0]    avg_t_q;
	// Turnaround of the finishing job, held while the division runs.
	logic [TAW-1:0]               ta_q;

	logic                         strobe_q;
	logic                         kind_q;
	logic                         cpu_o_q;
	logic [sjs_pkg::LAB_W-1:0]    lab_o_q;
	logic [sjs_pkg::TICK_W-1:0]   tick_o_q;
	logic [sjs_pkg::AVG_W-1:0]    avg_t_o_q;
	logic [sjs_pkg::AVG_W-1:0]    avg_w_o_q;
	logic                         last_o_q;

	logic                         accept;
	logic                         eligible;
	logic                         better;
	logic                         finishing;
	logic [TAW-1:0]               ta;
	logic                         div_start;
	logic [sjs_pkg::DIV_W-1:0]    div_num;
	logic [sjs_pkg::LEN_W-1:0]    div_den;
	logic                         div_done;
	logic [sjs_pkg::DIV_W-1:0]    div_quo;
	logic [sjs_pkg::AVG_W:0]      ta_sum_next;
	logic [sjs_pkg::WSUM_W:0]     w_sum_next;
	logic [sjs_pkg::AVG_W-1:0]    quo_sat;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = state_q != ST_IDLE;

	// A slot takes part when it has not started and its job has arrived.
	assign eligible = !started_q[scan_q] && (sjs_pkg::TICK_W'(rd_q.arr) <= tick_q);

	sjs_cmp u_cmp (
		.policy   (policy_q),
		.tick     (tick_q),
		.cand_arr (rd_q.arr),
		.cand_len (rd_q.len),
		.best_arr (best_q.arr),
		.best_len (best_q.len),
		.better   (better)
	);

	// The job of the current processor ends in this tick when one tick is left.
	assign finishing = cpu_busy_q[cur_cpu_q] && (cpu_rem_q[cur_cpu_q] == sjs_pkg::LEN_W'(1));
	assign ta = TAW'(tick_q) + TAW'(1) - TAW'(cpu_arr_q[cur_cpu_q]);

	// The divider serves the weighted term of each finish and both averages.
	always_comb begin
		div_start = 1'b0;
		div_num   = sjs_pkg::DIV_W'(ta) << 8;
		div_den   = cpu_len_q[cur_cpu_q];
		case (state_q)
			ST_RUN: begin
				div_start = finishing;
			end
			ST_SUM_T: begin
				div_start = 1'b1;
				div_num   = {ta_sum_q, 8'd0};
				div_den   = sjs_pkg::LEN_W'(loaded_q);
			end
			ST_SUM_W: begin
				div_start = 1'b1;
				div_num   = w_sum_q;
				div_den   = sjs_pkg::LEN_W'(loaded_q);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	sjs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign ta_sum_next = (sjs_pkg::AVG_W+1)'(ta_sum_q) + (sjs_pkg::AVG_W+1)'(ta_q);
	assign w_sum_next  = (sjs_pkg::WSUM_W+1)'(w_sum_q) + (sjs_pkg::WSUM_W+1)'(div_quo);
	assign quo_sat     = (div_quo > sjs_pkg::DIV_W'(sjs_pkg::MAX24)) ? sjs_pkg::MAX24
	                                                                 : div_quo[sjs_pkg::AVG_W-1:0];

	always_ff @(posedge clk) begin
		if (accept && (loaded_q < LW'(JOBS))) begin
			job_mem[loaded_q[IW-1:0]] <= '{
				arr: arrival_time,
				len: (run_length == '0) ? sjs_pkg::LEN_W'(1) : run_length,
				lab: job_label
			};
		end
		rd_q <= job_mem[scan_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			policy_q    <= sjs_pkg::POL_FCFS;
			started_q   <= '0;
			loaded_q    <= '0;
			done_cnt_q  <= '0;
			scan_q      <= '0;
			cur_cpu_q   <= 1'b0;
			tick_q      <= '0;
			found_q     <= 1'b0;
			cpu_busy_q  <= '0;
			cpu_rem_q   <= '{default: '0};
			ta_sum_q    <= '0;
			w_sum_q     <= '0;
			strobe_q    <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_we) begin
				policy_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (loaded_q < LW'(JOBS)) begin
							started_q[loaded_q[IW-1:0]] <= 1'b0;
							loaded_q <= loaded_q + LW'(1);
						end
						if (last_job) begin
							tick_q    <= '0;
							cur_cpu_q <= 1'b0;
							state_q   <= ST_PICK;
						end
					end
				end
				ST_PICK: begin
					found_q <= 1'b0;
					scan_q  <= '0;
					if (cpu_busy_q[cur_cpu_q]) begin
						state_q <= ST_RUN;
					end else if (loaded_q == '0) begin
						state_q <= ST_DISP;
					end else begin
						state_q <= ST_SCAN_A;
					end
				end
				ST_SCAN_A: begin
					state_q <= ST_SCAN_C;
				end
				ST_SCAN_C: begin
					if (eligible && (!found_q || better)) begin
						found_q     <= 1'b1;
						best_slot_q <= scan_q;
						best_q      <= rd_q;
					end
					if (LW'(scan_q) == loaded_q - LW'(1)) begin
						state_q <= ST_DISP;
					end else begin
						scan_q  <= scan_q + IW'(1);
						state_q <= ST_SCAN_A;
					end
				end
				ST_DISP: begin
					if (found_q) begin
						cpu_busy_q[cur_cpu_q] <= 1'b1;
						cpu_rem_q[cur_cpu_q]  <= best_q.len;
						cpu_arr_q[cur_cpu_q]  <= best_q.arr;
						cpu_len_q[cur_cpu_q]  <= best_q.len;
						started_q[best_slot_q] <= 1'b1;
						strobe_q  <= 1'b1;
						kind_q    <= sjs_pkg::KIND_DISPATCH;
						cpu_o_q   <= cur_cpu_q;
						lab_o_q   <= best_q.lab;
						tick_o_q  <= tick_q;
						avg_t_o_q <= '0;
						avg_w_o_q <= '0;
						last_o_q  <= 1'b0;
					end
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (cpu_busy_q[cur_cpu_q]) begin
						cpu_rem_q[cur_cpu_q] <= cpu_rem_q[cur_cpu_q] - sjs_pkg::LEN_W'(1);
					end
					if (finishing) begin
						ta_q    <= ta;
						state_q <= ST_FIN_W;
					end else begin
						state_q <= ST_NEXT;
					end
				end
				ST_FIN_W: begin
					if (div_done) begin
						ta_sum_q <= ta_sum_next[sjs_pkg::AVG_W] ? sjs_pkg::MAX24
						                                        : ta_sum_next[sjs_pkg::AVG_W-1:0];
						w_sum_q  <= w_sum_next[sjs_pkg::WSUM_W] ? {sjs_pkg::WSUM_W{1'b1}}
						                                        : w_sum_next[sjs_pkg::WSUM_W-1:0];
						cpu_busy_q[cur_cpu_q] <= 1'b0;
						done_cnt_q <= done_cnt_q + LW'(1);
						state_q    <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (!cur_cpu_q) begin
						cur_cpu_q <= 1'b1;
						state_q   <= ST_PICK;
					end else begin
						cur_cpu_q <= 1'b0;
						tick_q    <= tick_q + sjs_pkg::TICK_W'(1);
						state_q   <= (done_cnt_q < loaded_q) ? ST_PICK : ST_SUM_T;
					end
				end
				ST_SUM_T: begin
					state_q <= ST_SUM_TW;
				end
				ST_SUM_TW: begin
					if (div_done) begin
						avg_t_q <= quo_sat;
						state_q <= ST_SUM_W;
					end
				end
				ST_SUM_W: begin
					state_q <= ST_SUM_WW;
				end
				ST_SUM_WW: begin
					if (div_done) begin
						strobe_q  <= 1'b1;
						kind_q    <= sjs_pkg::KIND_SUMMARY;
						cpu_o_q   <= 1'b0;
						lab_o_q   <= '0;
						tick_o_q  <= '0;
						avg_t_o_q <= (loaded_q == '0) ? '0 : avg_t_q;
						avg_w_o_q <= (loaded_q == '0) ? '0 : quo_sat;
						last_o_q  <= 1'b1;
						state_q   <= ST_SUM_OUT;
					end
				end
				ST_SUM_OUT: begin
					// Clear the run so that a new load can begin.
					started_q  <= '0;
					loaded_q   <= '0;
					done_cnt_q <= '0;
					cpu_busy_q <= '0;
					cpu_rem_q  <= '{default: '0};
					tick_q     <= '0;
					ta_sum_q   <= '0;
					w_sum_q    <= '0;
					state_q    <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_strobe           = strobe_q;
	assign record_kind             = kind_q;
	assign cpu_index               = cpu_o_q;
	assign dispatched_label        = lab_o_q;
	assign dispatch_tick           = tick_o_q;
	assign avg_turnaround          = avg_t_o_q;
	assign avg_weighted_turnaround = avg_w_o_q;
	assign last_result             = last_o_q;

	// A result word is only produced by a running simulation.
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(state_q != ST_IDLE))
		else $error("result word without a running simulation");

	// No more jobs can finish than were loaded.
	a_done_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done_cnt_q <= loaded_q)
		else $error("finished count exceeds loaded count");

	// The final flag appears only on the summary word.
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last_result) |-> (record_kind == sjs_pkg::KIND_SUMMARY))
		else $error("last flag on a dispatch word");

	// The divider is never restarted while a finish waits on it.
	a_div_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN_W) |-> !div_start)
		else $error("divider restarted during a finish");

endmodule

// File: tb/tb_two_cpu_job_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_cpu_job_scheduler_top
// Self-checking bench for the two-processor job scheduler. Job sets are loaded
// under every policy, and a local schedule model predicts each dispatch record
// and the closing summary record. Records are checked as whole records as they
// appear, while the sender idles at random in several phases.
// ----------------------------------------------------------------------------
module tb_two_cpu_job_scheduler_top;

	localparam int unsigned JOBS = 16;
	// The fourth policy code is not defined and must act as first come.
	localparam logic [1:0] POL_SPARE = 2'd3;
	// Cycles in which no word is accepted or reported, while work is pending, before giving up.
	localparam int STALL_LIMIT = 400000;
	// Quiet time after a summary before the next policy write or job word.
	localparam int DRAIN_CYCLES = 200;

	typedef struct packed {
		logic                       kind;
		logic                       cpu;
		logic [sjs_pkg::LAB_W-1:0]  lab;
		logic [sjs_pkg::TICK_W-1:0] tick;
		logic [sjs_pkg::AVG_W-1:0]  avg_t;
		logic [sjs_pkg::AVG_W-1:0]  avg_w;
		logic                       last;
	} record_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_wdata = 2'd0;
	logic        start = 1'b0;
	logic        busy;
	logic [9:0]  arrival_time = '0;
	logic [7:0]  run_length = '0;
	logic [5:0]  job_label = '0;
	logic        last_job = 1'b0;
	logic        result_strobe;
	logic        record_kind;
	logic        cpu_index;
	logic [5:0]  dispatched_label;
	logic [15:0] dispatch_tick;
	logic [23:0] avg_turnaround;
	logic [23:0] avg_weighted_turnaround;
	logic        last_result;

	// Local copy of the job memory and the policy register.
	logic [sjs_pkg::ARR_W-1:0] arr_mem [JOBS];
	logic [sjs_pkg::LEN_W-1:0] len_mem [JOBS];
	logic [sjs_pkg::LAB_W-1:0] lab_mem [JOBS];
	int                        jobs_loaded = 0;
	logic [1:0]                cur_policy = sjs_pkg::POL_FCFS;

	record_t expected_records [$];
	int      errors = 0;
	int      words_sent = 0;
	int      records_checked = 0;
	int      summaries_checked = 0;
	int      stall_cycles = 0;
	int      send_idle_pct = 0;

	always #5 clk = ~clk;

	two_cpu_job_scheduler_top #(.JOBS(JOBS)) u_top (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cfg_we                 (cfg_we),
		.cfg_wdata              (cfg_wdata),
		.start                  (start),
		.busy                   (busy),
		.arrival_time           (arrival_time),
		.run_length             (run_length),
		.job_label              (job_label),
		.last_job               (last_job),
		.result_strobe          (result_strobe),
		.record_kind            (record_kind),
		.cpu_index              (cpu_index),
		.dispatched_label       (dispatched_label),
		.dispatch_tick          (dispatch_tick),
		.avg_turnaround         (avg_turnaround),
		.avg_weighted_turnaround(avg_weighted_turnaround),
		.last_result            (last_result)
	);

	// Runs the whole two-processor schedule for the loaded jobs and queues the
	// dispatch records in order, then the summary, then clears the job count.
	task automatic predict_schedule();
		bit      started [JOBS];
		bit      running [2];
		int      slot [2];
		int      remaining [2];
		int      t, done, best;
		longint  tsum, wsum, ta, wt, wi, wb, avg_t, avg_w;
		record_t rec;
		t = 0; done = 0; tsum = 0; wsum = 0;
		foreach (started[i]) started[i] = 1'b0;
		running[0] = 1'b0; running[1] = 1'b0;
		while (done < jobs_loaded) begin
			for (int c = 0; c < 2; c++) begin
				if (!running[c]) begin
					best = -1;
					for (int i = 0; i < jobs_loaded; i++) begin
						if (started[i] || arr_mem[i] > t)
							continue;
						if (best < 0) begin
							best = i;
						end else if (cur_policy == sjs_pkg::POL_SJF) begin
							if (len_mem[i] < len_mem[best])
								best = i;
						end else if (cur_policy == sjs_pkg::POL_HRRN) begin
							// Ratios compared by cross-multiplication.
							wi = longint'(t - arr_mem[i]) * len_mem[best];
							wb = longint'(t - arr_mem[best]) * len_mem[i];
							if (wi > wb)
								best = i;
						end
					end
					if (best >= 0) begin
						running[c] = 1'b1;
						slot[c] = best;
						remaining[c] = len_mem[best];
						started[best] = 1'b1;
						rec = '0;
						rec.kind = sjs_pkg::KIND_DISPATCH;
						rec.cpu = c[0];
						rec.lab = lab_mem[best];
						rec.tick = t[sjs_pkg::TICK_W-1:0];
						expected_records.push_back(rec);
					end
				end
				if (running[c]) begin
					remaining[c]--;
					if (remaining[c] == 0) begin
						// Turnaround counts the tick in which the job finishes.
						ta = t + 1 - arr_mem[slot[c]];
						wt = (ta << 8) / len_mem[slot[c]];
						tsum = (tsum + ta > sjs_pkg::MAX24) ? sjs_pkg::MAX24 : tsum + ta;
						wsum = (wsum + wt > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : wsum + wt;
						running[c] = 1'b0;
						done++;
					end
				end
			end
			t = (t + 1) & 16'hFFFF;
		end
		avg_t = (tsum << 8) / jobs_loaded;
		avg_w = wsum / jobs_loaded;
		rec = '0;
		rec.kind = sjs_pkg::KIND_SUMMARY;
		rec.avg_t = (avg_t > sjs_pkg::MAX24) ? sjs_pkg::MAX24 : avg_t[sjs_pkg::AVG_W-1:0];
		rec.avg_w = (avg_w > sjs_pkg::MAX24) ? sjs_pkg::MAX24 : avg_w[sjs_pkg::AVG_W-1:0];
		rec.last = 1'b1;
		expected_records.push_back(rec);
		jobs_loaded = 0;
	endtask

	// Sends one job word and waits for the handshake. A zero run length is
	// kept as one, and words beyond the memory size are dropped.
	task automatic send_job(input logic [9:0] arr, input logic [7:0] len,
			input logic [5:0] lab, input logic last);
		start <= 1'b1;
		arrival_time <= arr;
		run_length <= len;
		job_label <= lab;
		last_job <= last;
		do @(posedge clk); while (busy);
		words_sent++;
		if (jobs_loaded < JOBS) begin
			arr_mem[jobs_loaded] = arr;
			len_mem[jobs_loaded] = (len == 0) ? 8'd1 : len;
			lab_mem[jobs_loaded] = lab;
			jobs_loaded++;
		end
		if (last)
			predict_schedule();
		if ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Lowers start, waits for every queued record and lets the block settle.
	task automatic wait_for_summary();
		start <= 1'b0;
		while (expected_records.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_policy(input logic [1:0] pol);
		cfg_we <= 1'b1;
		cfg_wdata <= pol;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_policy = pol;
	endtask

	// One lone job at the far corners of every field, then a zero run length.
	task automatic test_field_extremes();
		write_policy(sjs_pkg::POL_FCFS);
		send_job(10'h3FF, 8'hFF, 6'h3F, 1'b1);
		wait_for_summary();
		send_job(10'h000, 8'h00, 6'h00, 1'b1);
		wait_for_summary();
	endtask

	// The same unsorted set under each policy code, so that picks differ.
	task automatic test_each_policy();
		logic [1:0] pols [4] = '{sjs_pkg::POL_FCFS, sjs_pkg::POL_SJF, sjs_pkg::POL_HRRN,
			POL_SPARE};
		foreach (pols[p]) begin
			write_policy(pols[p]);
			send_job(10'd0, 8'd6, 6'd1, 1'b0);
			send_job(10'd1, 8'd2, 6'd2, 1'b0);
			send_job(10'd0, 8'd9, 6'd3, 1'b0);
			send_job(10'd3, 8'd1, 6'd4, 1'b0);
			send_job(10'd2, 8'd2, 6'd5, 1'b1);
			wait_for_summary();
		end
	endtask

	// Eighteen words into sixteen slots: the last two are dropped, but the
	// final one still starts the run.
	task automatic test_memory_full();
		write_policy(sjs_pkg::POL_SJF);
		for (int i = 0; i < JOBS + 2; i++)
			send_job(i[9:0] / 2, 8'($urandom_range(1, 4)), i[5:0], i == JOBS + 1);
		wait_for_summary();
	endtask

	// Random job sets under a random policy until the phase has sent its share.
	task automatic test_random_sets(input int idle_pct, input int words);
		int         count, n;
		bit         unsorted;
		logic [9:0] arr;
		logic [7:0] len;
		send_idle_pct = idle_pct;
		count = 0;
		while (count < words) begin
			write_policy(2'($urandom_range(3)));
			n = ($urandom_range(7) == 0) ? $urandom_range(JOBS + 1, JOBS + 3)
				: $urandom_range(1, JOBS);
			unsorted = ($urandom_range(5) == 0);
			arr = 10'($urandom_range(8));
			for (int i = 0; i < n; i++) begin
				if (unsorted)
					arr = 10'($urandom_range(60));
				else if (i > 0)
					arr = arr + 10'($urandom_range(6));
				case ($urandom_range(39))
					0: len = 8'd0;
					1: len = 8'($urandom_range(128, 255));
					default: len = 8'($urandom_range(1, 24));
				endcase
				send_job(arr, len, 6'($urandom), i == n - 1);
			end
			count += n;
			wait_for_summary();
		end
	endtask

	// Records appear for one cycle only; each is taken at the edge ending it.
	always @(posedge clk) begin
		record_t got, want;
		if (arst_n && result_strobe) begin
			got = '{record_kind, cpu_index, dispatched_label, dispatch_tick,
				avg_turnaround, avg_weighted_turnaround, last_result};
			if (expected_records.size() == 0) begin
				$display("%0t: record with nothing expected: %p", $time, got);
				errors++;
			end else begin
				want = expected_records.pop_front();
				if (got !== want) begin
					$display("%0t: record mismatch, expected %p, actual %p",
						$time, want, got);
					errors++;
				end
				records_checked++;
				if (want.kind == sjs_pkg::KIND_SUMMARY)
					summaries_checked++;
			end
		end
	end

	// Watchdog: counts pending cycles in which no word moves either way.
	always @(posedge clk) begin
		if ((start && !busy) || result_strobe)
			stall_cycles <= 0;
		else if (start || expected_records.size() > 0)
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("tb_two_cpu_job_scheduler_top: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_field_extremes();
		test_each_policy();
		test_memory_full();
		// Phases: no idling, heavy sender idling, none again, light idling.
		test_random_sets(0, 105);
		test_random_sets(77, 105);
		test_random_sets(0, 105);
		test_random_sets(30, 105);
		$display("Sent %0d job words over all four policy codes.", words_sent);
		$display("Checked %0d records, %0d of them run summaries.",
			records_checked, summaries_checked);
		if (errors == 0 && expected_records.size() == 0)
			$display("tb_two_cpu_job_scheduler_top: PASS");
		else
			$display("tb_two_cpu_job_scheduler_top: FAIL");
		$finish;
	end

endmodule

// File: files.f
design/sjs_pkg.sv
design/sjs_div.sv
design/sjs_cmp.sv
design/two_cpu_job_scheduler_top.sv
tb/tb_two_cpu_job_scheduler_top.sv
